[sv/sthb_pkg.sv]
// shared types, constants and register codes for the stick to h-bridge duty block
package sthb_pkg;

    localparam int TIME_WIDTH_DEF  = 32;

    localparam int STICK_WIDTH     = 11;
    localparam int NOW_WIDTH       = 32;
    localparam int DUTY_WIDTH      = 7;
    localparam int SDUTY_WIDTH     = 8;
    localparam int DZ_WIDTH        = 8;
    localparam int FST_WIDTH       = 10;
    localparam int MD_WIDTH        = 7;
    localparam int BD_WIDTH        = 7;
    localparam int BT_WIDTH        = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // divider sizing: |dividend| stays below 2^19, divisor is 513..1023
    localparam int DIVIDEND_WIDTH  = 20;
    localparam int DIVISOR_WIDTH   = 10;
    localparam int QUOTIENT_WIDTH  = 11;
    localparam int DIV_STEPS       = 19;
    localparam int DIV_COUNT_WIDTH = $clog2(DIV_STEPS + 1);

    localparam int STICK_OFFSET    = 511;
    localparam int RUN_BASE        = 1023;
    localparam int DUTY_FULL       = 100;

    localparam logic [DZ_WIDTH-1:0]  DZ_RESET  = 8'd80;
    localparam logic [FST_WIDTH-1:0] FST_RESET = 10'd500;
    localparam logic [MD_WIDTH-1:0]  MD_RESET  = 7'd65;
    localparam logic [BD_WIDTH-1:0]  BD_RESET  = 7'd80;
    localparam logic [BT_WIDTH-1:0]  BT_RESET  = 16'd500;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_DEAD_ZONE  = 3'd0,
        CFG_FULL_SCALE = 3'd1,
        CFG_MIN_DUTY   = 3'd2,
        CFG_BOOST_DUTY = 3'd3,
        CFG_BOOST_TIME = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [DZ_WIDTH-1:0]  dead_zone;
        logic [FST_WIDTH-1:0] full_scale;
        logic [MD_WIDTH-1:0]  min_duty;
        logic [BD_WIDTH-1:0]  boost_duty;
        logic [BT_WIDTH-1:0]  boost_time;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

[sv/sthb_cfg_regs.sv]
// configuration register file with write channel
module sthb_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sthb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sthb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output sthb_pkg::cfg_t                       cfg
);

    sthb_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_zone  <= sthb_pkg::DZ_RESET;
            cfg_reg.full_scale <= sthb_pkg::FST_RESET;
            cfg_reg.min_duty   <= sthb_pkg::MD_RESET;
            cfg_reg.boost_duty <= sthb_pkg::BD_RESET;
            cfg_reg.boost_time <= sthb_pkg::BT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sthb_pkg::CFG_DEAD_ZONE:  cfg_reg.dead_zone  <= cfg_data[sthb_pkg::DZ_WIDTH-1:0];
                sthb_pkg::CFG_FULL_SCALE: cfg_reg.full_scale <= cfg_data[sthb_pkg::FST_WIDTH-1:0];
                sthb_pkg::CFG_MIN_DUTY:   cfg_reg.min_duty   <= cfg_data[sthb_pkg::MD_WIDTH-1:0];
                sthb_pkg::CFG_BOOST_DUTY: cfg_reg.boost_duty <= cfg_data[sthb_pkg::BD_WIDTH-1:0];
                sthb_pkg::CFG_BOOST_TIME: cfg_reg.boost_time <= cfg_data[sthb_pkg::BT_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

[sv/sthb_divider.sv]
// restoring signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
module sthb_divider
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic signed [sthb_pkg::DIVIDEND_WIDTH-1:0] dividend,
    input  logic        [sthb_pkg::DIVISOR_WIDTH-1:0]  divisor,
    output logic                                       done,
    output logic signed [sthb_pkg::QUOTIENT_WIDTH-1:0] quotient
);

    localparam int DW = sthb_pkg::DIVIDEND_WIDTH;
    localparam int VW = sthb_pkg::DIVISOR_WIDTH;
    localparam int QW = sthb_pkg::QUOTIENT_WIDTH;
    localparam int NS = sthb_pkg::DIV_STEPS;

    logic                                  busy_reg;
    logic                                  done_reg;
    logic                                  neg_reg;
    logic [sthb_pkg::DIV_COUNT_WIDTH-1:0]  count_reg;
    logic [VW-1:0]                         rem_reg;
    logic [NS-1:0]                         quo_reg;

    logic [DW-1:0] abs_dividend;
    logic [VW:0]   shifted;
    logic [VW+1:0] diff;
    logic          qbit;
    logic [QW-1:0] qmag;

    always_comb
    begin
        abs_dividend = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
        shifted      = {rem_reg, quo_reg[NS-1]};
        diff         = {1'b0, shifted} - {2'b00, divisor};
        qbit         = !diff[VW+1];
        qmag         = {1'b0, quo_reg[QW-2:0]};
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(QW'(-qmag)) : $signed(qmag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            count_reg <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                neg_reg   <= dividend[DW-1];
                count_reg <= sthb_pkg::DIV_COUNT_WIDTH'(NS);
                rem_reg   <= '0;
                quo_reg   <= abs_dividend[NS-1:0];
            end
            else if (busy_reg)
            begin
                rem_reg   <= qbit ? diff[VW-1:0] : shifted[VW-1:0];
                quo_reg   <= {quo_reg[NS-2:0], qbit};
                count_reg <= count_reg - 1'b1;
                if (count_reg == sthb_pkg::DIV_COUNT_WIDTH'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

[sv/stick_to_hbridge_duty_with_boost_core.sv]
// top level: stick to signed duty map, start boost window and h-bridge duty split
// an accepted item passes through ST_MUL, ST_START, ST_DIV and ST_FIN before its result lands in the output register
// items are taken one at a time: a new item waits until the 19 step divider and its sequencer are through with the last
// in_stall stays high while an item is in work and while a result waits for a free output slot
// reset: asynchronous active low; registers go to their defaults, last duty 0, boost off
// the output register lets a new item be accepted while the previous result is still held
module stick_to_hbridge_duty_with_boost_core
#(
    parameter int TIME_WIDTH = sthb_pkg::TIME_WIDTH_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [sthb_pkg::STICK_WIDTH-1:0] stick,
    input  logic                                  force_req,
    input  logic [sthb_pkg::NOW_WIDTH-1:0]        now_ms,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [sthb_pkg::DUTY_WIDTH-1:0]       forward_duty,
    output logic [sthb_pkg::DUTY_WIDTH-1:0]       reverse_duty,
    output logic                                  boosting,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sthb_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [sthb_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int SW = sthb_pkg::STICK_WIDTH;
    localparam int DW = sthb_pkg::DIVIDEND_WIDTH;
    localparam int QW = sthb_pkg::QUOTIENT_WIDTH;
    localparam int PW = sthb_pkg::SDUTY_WIDTH;
    localparam int OW = sthb_pkg::DUTY_WIDTH;
    // working width for the mapped duty before saturation
    localparam int MW = 13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FIN
    } state_t;

    // configuration registers
    sthb_pkg::cfg_t cfg;

    sthb_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    state_t                   state_reg;
    logic signed [SW-1:0]     stick_reg;
    logic                     force_reg;
    logic [TIME_WIDTH-1:0]    now_reg;
    logic signed [DW-1:0]     prod_reg;

    logic signed [PW-1:0]     last_duty_reg;
    logic                     boost_on_reg;
    logic [TIME_WIDTH-1:0]    boost_start_reg;

    logic                     out_valid_reg;
    logic [OW-1:0]            forward_reg;
    logic [OW-1:0]            reverse_reg;
    logic                     boosting_reg;

    // shared divider and its handshake
    sthb_pkg::div_ctrl_t      div_ctrl;
    logic signed [QW-1:0]     quotient;
    logic [sthb_pkg::DIVISOR_WIDTH-1:0] run;

    assign div_ctrl.start = (state_reg == ST_START);
    // run = 1023 - 2 * dead zone, never below 513
    assign run = sthb_pkg::DIVISOR_WIDTH'(sthb_pkg::RUN_BASE) - {1'b0, cfg.dead_zone, 1'b0};

    sthb_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctrl.start),
        .dividend (prod_reg),
        .divisor  (run),
        .done     (div_ctrl.done),
        .quotient (quotient)
    );

    // numerator of the map: (stick - 2*dz + 511) * 2*(100 - md)
    logic signed [SW:0]   x_off;
    logic signed [9:0]    act10;
    logic signed [9:0]    two_act;
    logic signed [SW+10:0] product;

    always_comb
    begin
        x_off   = $signed({stick_reg[SW-1], stick_reg}) - $signed({3'b000, cfg.dead_zone, 1'b0})
                  + $signed((SW+1)'(sthb_pkg::STICK_OFFSET));
        act10   = $signed(10'(sthb_pkg::DUTY_FULL)) - $signed({3'b000, cfg.min_duty});
        two_act = act10 <<< 1;
        product = x_off * two_act;
    end

    // final duty, boost window and change detect, valid while in ST_FIN
    logic [SW-1:0]           mag;
    logic                    in_dead;
    logic                    in_full;
    logic signed [MW-1:0]    q_ext;
    logic signed [MW-1:0]    act_ext;
    logic signed [MW-1:0]    md_ext;
    logic signed [MW-1:0]    bd_ext;
    logic signed [MW-1:0]    m_val;
    logic signed [MW-1:0]    raw_duty;
    logic signed [MW-1:0]    boost_duty;
    logic signed [MW-1:0]    sat_duty;
    logic                    boost_set;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic                    boosted;
    logic                    boost_on_next;
    logic [TIME_WIDTH-1:0]   boost_start_next;
    logic signed [PW-1:0]    duty_next;
    logic                    emit;
    logic                    slot_free;
    logic [OW-1:0]           forward_next;
    logic [OW-1:0]           reverse_next;
    // output register takes a new result at this edge
    logic                    load_out;

    always_comb
    begin
        mag     = stick_reg[SW-1] ? SW'(-stick_reg) : SW'(stick_reg);
        in_dead = mag < {3'b000, cfg.dead_zone};
        in_full = mag > {1'b0, cfg.full_scale};
        q_ext   = MW'(quotient);
        act_ext = MW'(act10);
        md_ext  = $signed({6'b0, cfg.min_duty});
        bd_ext  = $signed({6'b0, cfg.boost_duty});
        m_val   = q_ext - act_ext;

        if (in_dead)
            raw_duty = '0;
        else if (in_full)
            raw_duty = stick_reg[SW-1] ? -$signed(MW'(sthb_pkg::DUTY_FULL))
                                       : $signed(MW'(sthb_pkg::DUTY_FULL));
        else if (m_val > $signed(MW'(0)))
            raw_duty = m_val + md_ext;
        else
            raw_duty = m_val - md_ext;

        // boost window: a start from a stopped motor stamps now
        boost_set        = 1'b0;
        boosted          = 1'b0;
        boost_on_next    = boost_on_reg;
        boost_start_next = boost_start_reg;
        elapsed          = '0;
        boost_duty       = raw_duty;
        if (force_reg || (raw_duty == $signed(MW'(0))))
        begin
            boost_on_next = 1'b0;
        end
        else
        begin
            boost_set = (last_duty_reg == $signed(PW'(0)));
            if (boost_set)
            begin
                boost_start_next = now_reg;
            end
            elapsed = now_reg - boost_start_next;
            if (boost_set || boost_on_reg)
            begin
                if (elapsed < TIME_WIDTH'(cfg.boost_time))
                begin
                    boosted       = 1'b1;
                    boost_on_next = 1'b1;
                    boost_duty    = (raw_duty < $signed(MW'(0))) ? -bd_ext : bd_ext;
                end
                else
                begin
                    boost_on_next = 1'b0;
                end
            end
        end

        // saturate to plus or minus full scale
        if (boost_duty > $signed(MW'(sthb_pkg::DUTY_FULL)))
            sat_duty = $signed(MW'(sthb_pkg::DUTY_FULL));
        else if (boost_duty < -$signed(MW'(sthb_pkg::DUTY_FULL)))
            sat_duty = -$signed(MW'(sthb_pkg::DUTY_FULL));
        else
            sat_duty = boost_duty;

        duty_next    = PW'(sat_duty);
        emit         = (duty_next != last_duty_reg);
        slot_free    = !out_valid_reg || !out_stall;
        forward_next = (duty_next > $signed(PW'(0))) ? duty_next[OW-1:0] : '0;
        reverse_next = (duty_next < $signed(PW'(0))) ? OW'(-duty_next) : '0;
    end

    assign load_out     = (state_reg == ST_FIN) && emit && slot_free;
    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign forward_duty = forward_reg;
    assign reverse_duty = reverse_reg;
    assign boosting     = boosting_reg;

    // sequencer with item, boost state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            stick_reg       <= '0;
            force_reg       <= 1'b0;
            now_reg         <= '0;
            prod_reg        <= '0;
            last_duty_reg   <= '0;
            boost_on_reg    <= 1'b0;
            boost_start_reg <= '0;
            out_valid_reg   <= 1'b0;
            forward_reg     <= '0;
            reverse_reg     <= '0;
            boosting_reg    <= 1'b0;
        end
        else
        begin
            // new result loaded, or the held one taken downstream
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        stick_reg <= stick;
                        force_reg <= force_req;
                        now_reg   <= TIME_WIDTH'(now_ms);
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= DW'(product);
                    state_reg <= ST_START;
                end
                ST_START:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_ctrl.done)
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    // hold while a changed duty has no free output slot
                    if (!emit || slot_free)
                    begin
                        boost_on_reg    <= boost_on_next;
                        boost_start_reg <= boost_start_next;
                        state_reg       <= ST_IDLE;
                        if (emit)
                        begin
                            last_duty_reg <= duty_next;
                            forward_reg   <= forward_next;
                            reverse_reg   <= reverse_next;
                            boosting_reg  <= boosted;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // only one bridge side drives at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (forward_duty == '0) || (reverse_duty == '0))
        else $error("both bridge sides nonzero");

    // emitted duties never exceed full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (forward_duty <= OW'(sthb_pkg::DUTY_FULL))
                   && (reverse_duty <= OW'(sthb_pkg::DUTY_FULL)))
        else $error("duty above full scale");

    // the held duty stays inside plus or minus full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_duty_reg <= $signed(PW'(sthb_pkg::DUTY_FULL)))
        && (last_duty_reg >= -$signed(PW'(sthb_pkg::DUTY_FULL))))
        else $error("last duty out of range");

    // divider finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.done |-> (state_reg == ST_DIV))
        else $error("divider done outside wait state");

    // a new result always differs from the one before it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && emit && slot_free |=> (last_duty_reg != $past(last_duty_reg)))
        else $error("result emitted without duty change");

endmodule
